// File: sv/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  // Command codes carried in the low bits of the input tdata
  typedef enum logic [2:0] {
    CMD_ADD_FRONT    = 3'd0,
    CMD_ADD_BACK     = 3'd1,
    CMD_REMOVE_FRONT = 3'd2,
    CMD_REMOVE_BACK  = 3'd3,
    CMD_PEEK_FRONT   = 3'd4,
    CMD_PEEK_BACK    = 3'd5,
    CMD_REVERSE      = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } fsm_state_t;

  localparam int CMD_W       = 3;
  localparam int PUSH_W      = 32;
  localparam int PEEK_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

endpackage

// File: sv/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/double_ended_queue.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of signed words held in a ring buffer RAM.
// Input stream (s_*): one command per transaction; tdata carries command and
// push_value. Output stream (m_*): exactly one result per command carrying
// peek_value, status, occupancy and is_empty.
// On acceptance the RAM read of the end being addressed is issued; in the
// work stage, once the output register is free, the block updates head,
// count and direction flag, writes the RAM for an add and loads the output
// register. A new command is accepted only after the previous one has left
// the work stage; the result is valid once the output register is loaded.
// Reverse only toggles the direction flag, so it costs the same as any other
// command. Remove or peek on an empty queue and add to a full one return an
// error status and change nothing.
// If the receiver stalls, the result holds in the output register; one more
// command can still be accepted and waits in the work stage until the
// output register frees up.
// Reset (rst, synchronous) empties the queue, clears the direction flag and
// the output valid, and holds s_tready low while asserted; RAM contents are
// not cleared and need no pass.
module double_ended_queue #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] command, [34:3] push_value, [39:35] zero
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] peek_value, [33:32] status, [40:34] occupancy, [41] is_empty,
  // [47:42] zero
  output logic [47:0] m_tdata
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);

  deq_pkg::fsm_state_t state, state_next;

  logic [ADDR_W-1:0] head_index, head_index_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic              reversed, reversed_next;

  logic [deq_pkg::CMD_W-1:0]  cmd_q;
  logic [deq_pkg::PUSH_W-1:0] push_q;

  logic accept, done;

  // Ring positions derived from the current head and count
  logic [SUM_W-1:0]  sum_end, sum_tail;
  logic [ADDR_W-1:0] end_slot, tail_slot, before_head, after_head;

  always_comb begin
    sum_end  = SUM_W'(head_index) + SUM_W'(entry_count);
    sum_tail = sum_end - SUM_W'(1);
    end_slot  = (sum_end >= DEPTH_S) ? ADDR_W'(sum_end - DEPTH_S) : ADDR_W'(sum_end);
    tail_slot = (sum_tail >= DEPTH_S) ? ADDR_W'(sum_tail - DEPTH_S) : ADDR_W'(sum_tail);
    before_head = (head_index == '0) ? LAST_SLOT : head_index - ADDR_W'(1);
    after_head  = (head_index == LAST_SLOT) ? '0 : head_index + ADDR_W'(1);
  end

  // Read address chosen from the incoming command
  logic [deq_pkg::CMD_W-1:0] in_cmd;
  logic                      in_front;
  logic [ADDR_W-1:0]         rd_addr;

  always_comb begin
    in_cmd   = s_tdata[deq_pkg::CMD_W-1:0];
    in_front = (in_cmd == deq_pkg::CMD_REMOVE_FRONT) || (in_cmd == deq_pkg::CMD_PEEK_FRONT);
    rd_addr  = (in_front != reversed) ? head_index : tail_slot;
  end

  // FSM: next state
  always_comb begin
    state_next = state;
    unique case (state)
      deq_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = deq_pkg::ST_WORK;
      end
      deq_pkg::ST_WORK: begin
        if (!m_tvalid || m_tready) state_next = deq_pkg::ST_IDLE;
      end
      default: state_next = deq_pkg::ST_IDLE;
    endcase
  end

  // FSM: outputs
  always_comb begin
    s_tready = 1'b0;
    done     = 1'b0;
    unique case (state)
      deq_pkg::ST_IDLE: s_tready = !rst;
      deq_pkg::ST_WORK: done = !m_tvalid || m_tready;
      default: begin
        s_tready = 1'b0;
        done     = 1'b0;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // Command execution in the work stage
  logic [DATA_WIDTH-1:0]         rd_data;
  logic [DATA_WIDTH-1:0]         wr_data;
  logic [ADDR_W-1:0]             wr_addr;
  logic                          wr_en;
  logic [63:0]                   push_wide;
  logic signed [63:0]            rd_ext;
  logic [deq_pkg::PEEK_W-1:0]    peek_next;
  logic [deq_pkg::STATUS_W-1:0]  status_next;
  logic                          at_head;

  always_comb begin
    push_wide = {32'b0, push_q};
    wr_data   = push_wide[DATA_WIDTH-1:0];
    rd_ext    = 64'(signed'(rd_data));

    head_index_next  = head_index;
    entry_count_next = entry_count;
    reversed_next    = reversed;
    peek_next        = '0;
    status_next      = deq_pkg::STATUS_OK;
    wr_en            = 1'b0;
    wr_addr          = end_slot;
    at_head          = 1'b0;

    case (cmd_q)
      deq_pkg::CMD_ADD_FRONT, deq_pkg::CMD_ADD_BACK: begin
        at_head = (cmd_q == deq_pkg::CMD_ADD_FRONT) != reversed;
        if (entry_count == DEPTH_C) begin
          status_next = deq_pkg::STATUS_FULL;
        end else begin
          wr_en            = 1'b1;
          entry_count_next = entry_count + CNT_W'(1);
          if (at_head) begin
            head_index_next = before_head;
            wr_addr         = before_head;
          end
        end
      end
      deq_pkg::CMD_REMOVE_FRONT, deq_pkg::CMD_REMOVE_BACK: begin
        at_head = (cmd_q == deq_pkg::CMD_REMOVE_FRONT) != reversed;
        if (entry_count == '0) begin
          status_next = deq_pkg::STATUS_EMPTY;
        end else begin
          entry_count_next = entry_count - CNT_W'(1);
          if (at_head) head_index_next = after_head;
        end
      end
      deq_pkg::CMD_PEEK_FRONT, deq_pkg::CMD_PEEK_BACK: begin
        if (entry_count == '0) begin
          status_next = deq_pkg::STATUS_EMPTY;
        end else begin
          peek_next = rd_ext[deq_pkg::PEEK_W-1:0];
        end
      end
      deq_pkg::CMD_REVERSE: reversed_next = !reversed;
      default: ;  // no operation
    endcase
  end

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (done && wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= deq_pkg::ST_IDLE;
      head_index  <= '0;
      entry_count <= '0;
      reversed    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (done) begin
        head_index  <= head_index_next;
        entry_count <= entry_count_next;
        reversed    <= reversed_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers: capture command on accept, result on completion
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= in_cmd;
      push_q <= s_tdata[deq_pkg::CMD_W +: deq_pkg::PUSH_W];
    end
    if (done) begin
      m_tdata <= {6'b0,
                  (entry_count_next == '0),
                  deq_pkg::OCC_W'(entry_count_next),
                  status_next,
                  peek_next};
    end
  end

endmodule
